// File: rtl/rlss_pkg.sv
// Package for the RGB LED string serializer: opcodes, register indexes,
// configuration and command structs, and the store geometry.
// No dependencies.
`timescale 1ns / 1ps

package rlss_pkg;

  localparam int MAX_LEDS   = 64;
  localparam int LED_AW     = $clog2(MAX_LEDS);
  localparam int LED_CNT_W  = 7;
  localparam int WORD_BITS  = 24;
  localparam int BIT_PTR_W  = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [LED_CNT_W-1:0] MAX_CNT = LED_CNT_W'(MAX_LEDS);

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_GET   = 2'd1,
    OP_START = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIT_PERIOD = 3'd0,
    CFG_HIGH_TIME  = 3'd1,
    CFG_LOW_TIME   = 3'd2,
    CFG_LED_COUNT  = 3'd3,
    CFG_TRAILER    = 3'd4,
    CFG_FREE_RUN   = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [7:0]           bit_period;
    logic [7:0]           high_time;
    logic [7:0]           low_time;
    logic [LED_CNT_W-1:0] led_count;
    logic [11:0]          trailer_slots;
    logic                 free_running;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the input item and launch the store read
    logic commit;   // apply the item and load the output register
  } cmd_t;

endpackage

// File: rtl/rgb_led_string_serializer_core.sv
// Top level of the RGB LED string serializer: ties configuration registers,
// controller and datapath together. Depends on rlss_pkg, rlss_cfg,
// rlss_ctrl and rlss_dp.
`timescale 1ns / 1ps

// Usage:
//  Input channel (in_valid_i / in_stall_o) carries one operation per transfer:
//  set color, get color, start frame or one timer tick. Every item yields
//  exactly one result on the output channel (out_valid_o / out_stall_i).
//  Configuration writes go through cfg_valid_i / cfg_ready_o with a register
//  index and data; ready is always high. Write registers only while idle.
//  Sequence: an item is taken in the idle step and executed in the execute
//  step, because the 64-entry frame store has a registered read port; the
//  execute step waits while a held result fills the output register. The
//  result is written to the output register when the item executes.
//  A new item is taken while the previous result still waits in the output
//  register; if the receiver stalls, the next item waits in the execute step
//  until the output register drains, and the input side stalls meanwhile.
//  Reset clears all control state and the per-entry valid flags of the
//  store, so every color reads as zero at once; no clearing pass is needed.
//  Configuration returns to its documented reset values.
module rgb_led_string_serializer_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       op_i,
  input  logic [5:0]                       led_index_i,
  input  logic [7:0]                       red_in_i,
  input  logic [7:0]                       green_in_i,
  input  logic [7:0]                       blue_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             line_level_o,
  output logic                             busy_res_o,
  output logic                             frame_done_o,
  output logic [7:0]                       red_out_o,
  output logic [7:0]                       green_out_o,
  output logic [7:0]                       blue_out_o,
  output logic                             index_error_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rlss_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rlss_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  rlss_pkg::cfg_t cfg;
  rlss_pkg::cmd_t cmd;

  rlss_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rlss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  rlss_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_i         (cfg),
    .op_i          (op_i),
    .led_index_i   (led_index_i),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .line_level_o  (line_level_o),
    .busy_res_o    (busy_res_o),
    .frame_done_o  (frame_done_o),
    .red_out_o     (red_out_o),
    .green_out_o   (green_out_o),
    .blue_out_o    (blue_out_o),
    .index_error_o (index_error_o)
  );

endmodule

// File: rtl/rlss_cfg.sv
// Configuration register file for the RGB LED string serializer.
// Depends on rlss_pkg.
`timescale 1ns / 1ps

module rlss_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rlss_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rlss_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output rlss_pkg::cfg_t                   cfg_o
);

  rlss_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (rlss_pkg::cfg_idx_e'(cfg_index_i))
        rlss_pkg::CFG_BIT_PERIOD: cfg_d.bit_period    = cfg_data_i[7:0];
        rlss_pkg::CFG_HIGH_TIME:  cfg_d.high_time     = cfg_data_i[7:0];
        rlss_pkg::CFG_LOW_TIME:   cfg_d.low_time      = cfg_data_i[7:0];
        rlss_pkg::CFG_LED_COUNT:  cfg_d.led_count     = cfg_data_i[rlss_pkg::LED_CNT_W-1:0];
        rlss_pkg::CFG_TRAILER:    cfg_d.trailer_slots = cfg_data_i[11:0];
        rlss_pkg::CFG_FREE_RUN:   cfg_d.free_running  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_period    <= 8'd10;
      cfg_q.high_time     <= 8'd7;
      cfg_q.low_time      <= 8'd3;
      cfg_q.led_count     <= rlss_pkg::MAX_CNT;
      cfg_q.trailer_slots <= 12'd0;
      cfg_q.free_running  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: rtl/rlss_ctrl.sv
// Controller for the RGB LED string serializer: input/output handshake and
// the two-step accept/execute sequence. Depends on rlss_pkg.
`timescale 1ns / 1ps

module rlss_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rlss_pkg::cmd_t     cmd_o
);

  rlss_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      rlss_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = rlss_pkg::ST_EXEC;
        end
      end
      rlss_pkg::ST_EXEC: begin
        // output slot is free or drains this cycle
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = rlss_pkg::ST_IDLE;
        end
      end
      default: state_d = rlss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rlss_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/rlss_dp.sv
// Datapath for the RGB LED string serializer: frame store, frame sequencing
// counters, bit shifter and output register. Depends on rlss_pkg.
`timescale 1ns / 1ps

module rlss_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rlss_pkg::cmd_t                    cmd_i,
  input  rlss_pkg::cfg_t                    cfg_i,
  input  logic [1:0]                        op_i,
  input  logic [5:0]                        led_index_i,
  input  logic [7:0]                        red_in_i,
  input  logic [7:0]                        green_in_i,
  input  logic [7:0]                        blue_in_i,
  output logic                              line_level_o,
  output logic                              busy_res_o,
  output logic                              frame_done_o,
  output logic [7:0]                        red_out_o,
  output logic [7:0]                        green_out_o,
  output logic [7:0]                        blue_out_o,
  output logic                              index_error_o
);

  localparam int AW = rlss_pkg::LED_AW;
  localparam int CW = rlss_pkg::LED_CNT_W;
  localparam int WB = rlss_pkg::WORD_BITS;
  localparam int BW = rlss_pkg::BIT_PTR_W;

  // captured item
  rlss_pkg::op_e op_q;
  logic [5:0]    idx_q;
  logic [7:0]    red_q, green_q, blue_q;

  // frame store; an entry never written reads as zero
  logic [WB-1:0]       mem [rlss_pkg::MAX_LEDS];
  logic [rlss_pkg::MAX_LEDS-1:0] vld_q;
  logic [WB-1:0]       rd_word_q;
  logic                rd_vld_q;
  logic [AW-1:0]       rd_addr;
  logic [WB-1:0]       word;

  // frame state
  logic          sending_q, sending_d;
  logic [CW-1:0] led_ptr_q, led_ptr_d;
  logic [BW-1:0] bit_ptr_q, bit_ptr_d;
  logic [7:0]    tick_q, tick_d;
  logic [11:0]   trl_q, trl_d;
  logic [WB-1:0] shift_q, shift_d;

  // result
  logic       level, done, err, wr_en;
  logic [7:0] ro, go, bo;

  logic [CW-1:0] count;
  logic [7:0]    period;

  assign count  = (cfg_i.led_count > rlss_pkg::MAX_CNT) ? rlss_pkg::MAX_CNT : cfg_i.led_count;
  assign period = (cfg_i.bit_period == 8'd0) ? 8'd1 : cfg_i.bit_period;

  assign rd_addr = (rlss_pkg::op_e'(op_i) == rlss_pkg::OP_GET) ? led_index_i[AW-1:0]
                                                                : led_ptr_q[AW-1:0];
  assign word    = rd_vld_q ? rd_word_q : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= rlss_pkg::op_e'(op_i);
      idx_q     <= led_index_i;
      red_q     <= red_in_i;
      green_q   <= green_in_i;
      blue_q    <= blue_in_i;
      rd_word_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[idx_q[AW-1:0]] <= {green_q, red_q, blue_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.capture) rd_vld_q <= vld_q[rd_addr];
      if (wr_en)         vld_q[idx_q[AW-1:0]] <= 1'b1;
    end
  end

  always_comb begin
    logic [8:0]    tick_inc;
    logic [WB-1:0] sw;
    logic [BW-1:0] bp_inc;
    tick_inc  = {1'b0, tick_q} + 9'd1;
    sw        = shift_q;
    bp_inc    = bit_ptr_q + BW'(1);
    sending_d = sending_q;
    led_ptr_d = led_ptr_q;
    bit_ptr_d = bit_ptr_q;
    tick_d    = tick_q;
    trl_d     = trl_q;
    shift_d   = shift_q;
    level     = 1'b0;
    done      = 1'b0;
    err       = 1'b0;
    wr_en     = 1'b0;
    ro        = '0;
    go        = '0;
    bo        = '0;
    case (op_q) inside
      rlss_pkg::OP_SET, rlss_pkg::OP_GET: begin
        if ({1'b0, idx_q} >= count) begin
          err = 1'b1;
        end else if (op_q == rlss_pkg::OP_SET) begin
          wr_en = cmd_i.commit;
        end else begin
          go = word[23:16];
          ro = word[15:8];
          bo = word[7:0];
        end
      end
      rlss_pkg::OP_START: begin
        if (!sending_q) begin
          sending_d = 1'b1;
          led_ptr_d = '0;
          bit_ptr_d = '0;
          tick_d    = '0;
          trl_d     = '0;
          shift_d   = '0;
        end
      end
      default: begin
        if (sending_q) begin
          if (led_ptr_q < count) begin
            // first tick of an LED loads its word from the store
            if (bit_ptr_q == '0 && tick_q == '0) sw = word;
            level = ({1'b0, tick_q} < {1'b0, sw[WB-1] ? cfg_i.high_time : cfg_i.low_time});
            if (tick_inc >= {1'b0, period}) begin
              tick_d  = '0;
              shift_d = {sw[WB-2:0], 1'b0};
              if (bp_inc >= BW'(WB)) begin
                bit_ptr_d = '0;
                led_ptr_d = led_ptr_q + CW'(1);
              end else begin
                bit_ptr_d = bp_inc;
              end
            end else begin
              tick_d  = tick_inc[7:0];
              shift_d = sw;
            end
          end else if (trl_q < cfg_i.trailer_slots) begin
            if (tick_inc >= {1'b0, period}) begin
              tick_d = '0;
              trl_d  = trl_q + 12'd1;
            end else begin
              tick_d = tick_inc[7:0];
            end
          end
          if (led_ptr_d >= count && trl_d >= cfg_i.trailer_slots) begin
            done      = 1'b1;
            sending_d = cfg_i.free_running;
            led_ptr_d = '0;
            bit_ptr_d = '0;
            tick_d    = '0;
            trl_d     = '0;
            if (cfg_i.free_running) shift_d = '0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q <= 1'b0;
      led_ptr_q <= '0;
      bit_ptr_q <= '0;
      tick_q    <= '0;
      trl_q     <= '0;
      shift_q   <= '0;
    end else if (cmd_i.commit) begin
      sending_q <= sending_d;
      led_ptr_q <= led_ptr_d;
      bit_ptr_q <= bit_ptr_d;
      tick_q    <= tick_d;
      trl_q     <= trl_d;
      shift_q   <= shift_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      line_level_o  <= level;
      busy_res_o    <= sending_d;
      frame_done_o  <= done;
      red_out_o     <= ro;
      green_out_o   <= go;
      blue_out_o    <= bo;
      index_error_o <= err;
    end
  end

endmodule

// File: rtl/rlss_checker.sv
// Port-level checks for the RGB LED string serializer, bound to the top level.
// Depends on rgb_led_string_serializer_core.
`timescale 1ns / 1ps

module rlss_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       line_level_o,
  input logic       busy_res_o,
  input logic       frame_done_o,
  input logic [7:0] red_out_o,
  input logic [7:0] green_out_o,
  input logic [7:0] blue_out_o,
  input logic       index_error_o
);

  // an output held by the receiver stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // a stalled result does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(line_level_o) && $stable(busy_res_o) &&
      $stable(frame_done_o) && $stable(red_out_o) && $stable(green_out_o) &&
      $stable(blue_out_o) && $stable(index_error_o))
    else $error("stalled result changed");

  // an input transfer is followed by the execute cycle
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken in execute cycle");

  // rejected index returns no color
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && index_error_o |-> red_out_o == 8'd0 && green_out_o == 8'd0 &&
      blue_out_o == 8'd0)
    else $error("color returned with index error");

  // line only driven high during a frame
  a_line_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_level_o && !frame_done_o |-> busy_res_o)
    else $error("line high outside a frame");

endmodule

bind rgb_led_string_serializer_core rlss_checker u_rlss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .line_level_o  (line_level_o),
  .busy_res_o    (busy_res_o),
  .frame_done_o  (frame_done_o),
  .red_out_o     (red_out_o),
  .green_out_o   (green_out_o),
  .blue_out_o    (blue_out_o),
  .index_error_o (index_error_o)
);

// File: test/rlss_string_checker.sv
// Scoreboard for the RGB LED string serializer: watches the input, result and
// register write channels, predicts each result and compares it field by field.
// Depends on rlss_pkg.
`timescale 1ns / 1ps

module rlss_string_checker
  import rlss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_o,
  input  logic [1:0]            op_i,
  input  logic [5:0]            led_index_i,
  input  logic [7:0]            red_in_i,
  input  logic [7:0]            green_in_i,
  input  logic [7:0]            blue_in_i,
  input  logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  logic                  line_level_o,
  input  logic                  busy_res_o,
  input  logic                  frame_done_o,
  input  logic [7:0]            red_out_o,
  input  logic [7:0]            green_out_o,
  input  logic [7:0]            blue_out_o,
  input  logic                  index_error_o,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_cnt,
  output int                    pending_cnt,
  output int                    result_cnt,
  output int                    frame_cnt,
  output int                    index_err_cnt
);

  typedef struct packed {
    logic       level;
    logic       busy;
    logic       done;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       err;
  } led_result_t;

  // shadow of the register file
  logic [7:0]           bit_period_q;
  logic [7:0]           high_time_q;
  logic [7:0]           low_time_q;
  logic [LED_CNT_W-1:0] led_count_q;
  logic [11:0]          trailer_q;
  logic                 free_run_q;

  // shadow of the serializer
  logic [23:0] colors [MAX_LEDS];
  logic        sending;
  int          led_ptr;
  int          bit_ptr;
  int          tick_cnt;
  int          trailer_cnt;
  logic [23:0] shift_word;

  led_result_t expected_results [$];

  function automatic void restart_frame();
    sending     = 1'b1;
    led_ptr     = 0;
    bit_ptr     = 0;
    tick_cnt    = 0;
    trailer_cnt = 0;
    shift_word  = '0;
  endfunction

  function automatic led_result_t step_string(op_e op, logic [5:0] idx, logic [7:0] r,
                                              logic [7:0] g, logic [7:0] b);
    led_result_t res;
    int          count;
    int          period;
    logic        bit_v;
    res    = '0;
    count  = (led_count_q > MAX_LEDS) ? MAX_LEDS : int'(led_count_q);
    period = (bit_period_q == 0) ? 1 : int'(bit_period_q);
    case (op)
      OP_SET, OP_GET: begin
        if (int'(idx) >= count) begin
          res.err = 1'b1;
        end else if (op == OP_SET) begin
          colors[idx] = {g, r, b};
        end else begin
          {res.green, res.red, res.blue} = colors[idx];
        end
      end
      OP_START: begin
        if (!sending) restart_frame();
      end
      default: begin
        if (sending) begin
          if (led_ptr < count) begin
            // word is loaded when its first bit slot begins
            if (bit_ptr == 0 && tick_cnt == 0) shift_word = colors[led_ptr];
            bit_v     = shift_word[23];
            res.level = (tick_cnt < int'(bit_v ? high_time_q : low_time_q));
            tick_cnt++;
            if (tick_cnt >= period) begin
              tick_cnt   = 0;
              shift_word = shift_word << 1;
              bit_ptr++;
              if (bit_ptr >= WORD_BITS) begin
                bit_ptr = 0;
                led_ptr++;
              end
            end
          end else if (trailer_cnt < int'(trailer_q)) begin
            tick_cnt++;
            if (tick_cnt >= period) begin
              tick_cnt = 0;
              trailer_cnt++;
            end
          end
          if (led_ptr >= count && trailer_cnt >= int'(trailer_q)) begin
            res.done = 1'b1;
            if (free_run_q) begin
              restart_frame();
            end else begin
              sending     = 1'b0;
              led_ptr     = 0;
              bit_ptr     = 0;
              tick_cnt    = 0;
              trailer_cnt = 0;
            end
          end
        end
      end
    endcase
    res.busy = sending;
    return res;
  endfunction

  task automatic report_failure(string msg);
    $display("[%0t] ERROR result %0d: %s", $time, result_cnt, msg);
    fail_cnt++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_failure($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q  = 8'd10;
      high_time_q   = 8'd7;
      low_time_q    = 8'd3;
      led_count_q   = MAX_CNT;
      trailer_q     = '0;
      free_run_q    = 1'b0;
      foreach (colors[i]) colors[i] = '0;
      sending       = 1'b0;
      led_ptr       = 0;
      bit_ptr       = 0;
      tick_cnt      = 0;
      trailer_cnt   = 0;
      shift_word    = '0;
      expected_results.delete();
      pending_cnt   = 0;
      fail_cnt      = 0;
      result_cnt    = 0;
      frame_cnt     = 0;
      index_err_cnt = 0;
    end else begin
      led_result_t want;
      // a result never leaves before its item is taken, so check first
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_failure("result transfer with nothing expected");
        end else begin
          want = expected_results.pop_front();
          check_field("line_level", int'(line_level_o), int'(want.level));
          check_field("busy", int'(busy_res_o), int'(want.busy));
          check_field("frame_done", int'(frame_done_o), int'(want.done));
          check_field("red_out", int'(red_out_o), int'(want.red));
          check_field("green_out", int'(green_out_o), int'(want.green));
          check_field("blue_out", int'(blue_out_o), int'(want.blue));
          check_field("index_error", int'(index_error_o), int'(want.err));
          if (want.done) frame_cnt++;
          if (want.err) index_err_cnt++;
        end
        result_cnt++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_BIT_PERIOD: bit_period_q = cfg_data_i[7:0];
          CFG_HIGH_TIME:  high_time_q  = cfg_data_i[7:0];
          CFG_LOW_TIME:   low_time_q   = cfg_data_i[7:0];
          CFG_LED_COUNT:  led_count_q  = cfg_data_i[LED_CNT_W-1:0];
          CFG_TRAILER:    trailer_q    = cfg_data_i[11:0];
          CFG_FREE_RUN:   free_run_q   = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(step_string(op_e'(op_i), led_index_i, red_in_i,
                                               green_in_i, blue_in_i));
      end
      pending_cnt = expected_results.size();
    end
  end

endmodule

// File: test/tb_rgb_led_string_serializer_core.sv
// Testbench top for rgb_led_string_serializer_core: clock, reset, stimulus and
// verdict. Depends on rlss_pkg, the core and rlss_string_checker.
`timescale 1ns / 1ps

module tb_rgb_led_string_serializer_core;
  import rlss_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SEGMENTS    = 9;
  localparam int SEG_ITEMS   = 172;

  // register settings per random segment; extremes spread across them
  int seg_period  [SEGMENTS] = '{1, 2, 0, 3, 255, 1, 4, 1, 2};
  int seg_high    [SEGMENTS] = '{1, 2, 255, 1, 200, 0, 3, 1, 1};
  int seg_low     [SEGMENTS] = '{0, 1, 255, 2, 0, 1, 1, 0, 1};
  int seg_leds    [SEGMENTS] = '{1, 2, 0, 1, 127, 3, 1, 2, 0};
  int seg_trailer [SEGMENTS] = '{2, 0, 3, 4095, 0, 1, 0, 0, 0};
  int seg_free    [SEGMENTS] = '{0, 1, 1, 0, 0, 1, 0, 1, 0};

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic [1:0]            op_i        = OP_TICK;
  logic [5:0]            led_index_i = '0;
  logic [7:0]            red_in_i    = '0;
  logic [7:0]            green_in_i  = '0;
  logic [7:0]            blue_in_i   = '0;
  logic                  out_stall_i = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_BIT_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  logic       in_stall_o;
  logic       out_valid_o;
  logic       line_level_o;
  logic       busy_res_o;
  logic       frame_done_o;
  logic [7:0] red_out_o;
  logic [7:0] green_out_o;
  logic [7:0] blue_out_o;
  logic       index_error_o;
  logic       cfg_ready_o;

  int fail_cnt;
  int pending_cnt;
  int result_cnt;
  int frame_cnt;
  int index_err_cnt;

  int idle_pct  = 0;
  int stall_pct = 0;
  int cur_leds  = MAX_LEDS;
  int item_cnt  = 0;
  int cycle_cnt = 0;

  rgb_led_string_serializer_core dut (.*);

  rlss_string_checker checker_i (.*);

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending_cnt);
    $display("Simulation FAILED");
    $finish;
  end

  // entered and left at a falling edge
  task automatic send_item(op_e op, int idx, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    led_index_i <= idx[5:0];
    red_in_i    <= r;
    green_in_i  <= g;
    blue_in_i   <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    item_cnt++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic load_settings(int period, int high, int low, int leds, int trailer, int free);
    wait_idle();
    write_reg(CFG_BIT_PERIOD, period);
    write_reg(CFG_HIGH_TIME, high);
    write_reg(CFG_LOW_TIME, low);
    write_reg(CFG_LED_COUNT, leds);
    write_reg(CFG_TRAILER, trailer);
    write_reg(CFG_FREE_RUN, free);
    cfg_valid_i <= 1'b0;
    cur_leds = (leds > MAX_LEDS) ? MAX_LEDS : leds;
  endtask

  // mostly ticks so frames run to completion; indices mostly in range
  task automatic random_item();
    int   pick;
    int   idx;
    op_e  op;
    pick = $urandom_range(99);
    if (cur_leds > 0 && $urandom_range(99) < 85) idx = $urandom_range(cur_leds - 1);
    else idx = $urandom_range(63);
    if (pick < 60) op = OP_TICK;
    else if (pick < 78) op = OP_SET;
    else if (pick < 90) op = OP_GET;
    else op = OP_START;
    send_item(op, idx, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)));
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // store extremes and readback, a never-written entry, a tick while idle
    send_item(OP_SET, 63, 8'hff, 8'h00, 8'hff);
    send_item(OP_SET, 0, 8'h00, 8'hff, 8'h00);
    send_item(OP_GET, 63, 8'h00, 8'h00, 8'h00);
    send_item(OP_GET, 0, 8'hff, 8'hff, 8'hff);
    send_item(OP_GET, 31, 8'h00, 8'h00, 8'h00);
    send_item(OP_TICK, 0, 8'h00, 8'h00, 8'h00);

    // empty string: index errors, start while busy, frame ends on first tick
    load_settings(0, 255, 0, 0, 0, 0);
    send_item(OP_SET, 0, 8'h12, 8'h34, 8'h56);
    send_item(OP_GET, 63, 8'h00, 8'h00, 8'h00);
    send_item(OP_START, 0, 8'h00, 8'h00, 8'h00);
    send_item(OP_START, 0, 8'h00, 8'h00, 8'h00);
    send_item(OP_TICK, 0, 8'h00, 8'h00, 8'h00);
    send_item(OP_TICK, 0, 8'h00, 8'h00, 8'h00);

    // one LED, zero period acting as one tick, free running, set mid-frame
    load_settings(0, 1, 0, 1, 1, 1);
    send_item(OP_SET, 1, 8'h00, 8'h00, 8'h00);
    send_item(OP_START, 0, 8'h00, 8'h00, 8'h00);
    repeat (10) send_item(OP_TICK, 0, 8'h00, 8'h00, 8'h00);
    send_item(OP_SET, 0, 8'ha5, 8'h5a, 8'hc3);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      load_settings(seg_period[seg], seg_high[seg], seg_low[seg], seg_leds[seg],
                    seg_trailer[seg], seg_free[seg]);
      if (seg < 3) begin
        idle_pct  = 27;
        stall_pct = 73;
      end else if (seg < 6) begin
        idle_pct  = 73;
        stall_pct = 27;
      end else begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      repeat (SEG_ITEMS) random_item();
    end

    wait_idle();
    repeat (8) @(negedge clk_i);
    $display("Sent %0d items under %0d register settings, %0d results compared.",
             item_cnt, SEGMENTS + 3, result_cnt);
    $display("Saw %0d finished frames and %0d out-of-range set/get accesses.",
             frame_cnt, index_err_cnt);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: rgb_led_string_serializer_core.f
rtl/rlss_pkg.sv
rtl/rlss_cfg.sv
rtl/rlss_ctrl.sv
rtl/rlss_dp.sv
rtl/rgb_led_string_serializer_core.sv
rtl/rlss_checker.sv
test/rlss_string_checker.sv
test/tb_rgb_led_string_serializer_core.sv
